@@ sv/ufe_pkg.sv @@
// Package for the UTF-8 filtering encoder.
// Holds the queue entry type, code point limits and queue sizing; no dependencies.
package ufe_pkg;

    localparam int unsigned CpWidth    = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned MaxBytes   = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [CpWidth-1:0] MaxScalar = 32'h0010_FFFF;

    // UTF-8 lead and continuation marks.
    localparam logic [ByteWidth-1:0] Lead2Mark = 8'hC0;
    localparam logic [ByteWidth-1:0] Lead3Mark = 8'hE0;
    localparam logic [ByteWidth-1:0] Lead4Mark = 8'hF0;
    localparam logic [ByteWidth-1:0] ContMark  = 8'h80;

    // Sequence length minus one.
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    // One encoded code point, bytes in output order (lead byte at index 0).
    typedef struct packed {
        t_len                                 len_m1;
        logic [MaxBytes-1:0][ByteWidth-1:0]   bytes;
    } t_entry;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

endpackage

@@ sv/utf8_filtering_encoder.sv @@
// UTF-8 filtering encoder, top level: one 32-bit code point in, one to four
// bytes out with tlast on the final byte, or nothing for a dropped value.
// Depends on ufe_pkg, ufe_front, ufe_queue and ufe_back.
//
// The output sends one byte per cycle while i_m_axis_tready is high, and a
// dropped value is accepted with no output. The input takes a code point
// every cycle while the two-entry queue between the classifier and the byte
// serializer has room, so the sustained rate is set by the serializer.
// A kept code point is registered in the queue and then in the serializer
// before it reaches the output.
// encode_all resets to 0 (filtering on) and is written through i_cfg_wr_en; the
// user must write it only while the block is idle, which the block does not enforce.
module utf8_filtering_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,      // encode_all
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,     // [31:0] code_point
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,     // [7:0] out_byte
    output logic        o_m_axis_tlast      // last_byte
);
    import ufe_pkg::*;

    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    t_entry  w_entry;
    t_q_head w_head;

    ufe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tvalid      (i_s_axis_tvalid),
        .o_tready      (o_s_axis_tready),
        .i_tdata       (i_s_axis_tdata),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    ufe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    ufe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A value beyond the Unicode range never enters the queue.
    a_no_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && (i_s_axis_tdata > MaxScalar)) |-> !w_push)
        else $error("out-of-range code point was queued");

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");

    // The serializer only pops an entry that is present.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    // After the last byte with nothing queued, the output goes idle.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast && !w_head.valid)
        |=> !o_m_axis_tvalid)
        else $error("output stayed valid after final byte");
`endif

endmodule

@@ sv/ufe_front.sv @@
// Front end of the UTF-8 filtering encoder: holds the encode_all register,
// filters each code point and formats its UTF-8 bytes. Depends on ufe_pkg.
module ufe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [ufe_pkg::CpWidth-1:0] i_tdata,
    input  logic                  i_q_full,
    output logic                  o_push,
    output ufe_pkg::t_entry       o_entry
);
    import ufe_pkg::*;

    logic r_encode_all;
    logic w_out_of_range;
    logic w_filtered;
    logic w_keep;
    logic [20:0] w_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encode_all <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_encode_all <= i_cfg_wr_data;
        end
    end

    assign w_out_of_range = (i_tdata > MaxScalar);
    assign w_cp           = i_tdata[20:0];

    // Controls except line feed, DEL and C1, surrogates, the BMP end
    // noncharacters and the two private-use planes short of their last two values.
    always_comb begin
        w_filtered = 1'b0;
        if (w_cp < 21'h20 && w_cp != 21'h0A)             w_filtered = 1'b1;
        if (w_cp >= 21'h7F && w_cp <= 21'h9F)             w_filtered = 1'b1;
        if (w_cp >= 21'hD800 && w_cp <= 21'hDFFF)         w_filtered = 1'b1;
        if (w_cp >= 21'hFFFE && w_cp <= 21'hFFFF)         w_filtered = 1'b1;
        if (w_cp >= 21'hF0000 && w_cp <= 21'hFFFFD)       w_filtered = 1'b1;
        if (w_cp >= 21'h100000 && w_cp <= 21'h10FFFD)     w_filtered = 1'b1;
    end

    assign w_keep   = !w_out_of_range && (r_encode_all || !w_filtered);
    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full && w_keep;

    always_comb begin
        o_entry.bytes = '0;
        priority if (w_cp < 21'h80) begin
            o_entry.len_m1   = LEN_1;
            o_entry.bytes[0] = {1'b0, w_cp[6:0]};
        end else if (w_cp < 21'h800) begin
            o_entry.len_m1   = LEN_2;
            o_entry.bytes[0] = Lead2Mark | {3'b000, w_cp[10:6]};
            o_entry.bytes[1] = ContMark | {2'b00, w_cp[5:0]};
        end else if (w_cp < 21'h10000) begin
            o_entry.len_m1   = LEN_3;
            o_entry.bytes[0] = Lead3Mark | {4'b0000, w_cp[15:12]};
            o_entry.bytes[1] = ContMark | {2'b00, w_cp[11:6]};
            o_entry.bytes[2] = ContMark | {2'b00, w_cp[5:0]};
        end else begin
            o_entry.len_m1   = LEN_4;
            o_entry.bytes[0] = Lead4Mark | {5'b00000, w_cp[20:18]};
            o_entry.bytes[1] = ContMark | {2'b00, w_cp[17:12]};
            o_entry.bytes[2] = ContMark | {2'b00, w_cp[11:6]};
            o_entry.bytes[3] = ContMark | {2'b00, w_cp[5:0]};
        end
    end

endmodule

@@ sv/ufe_queue.sv @@
// Short queue of encoded entries between front and back end.
// Depends on ufe_pkg for the entry type and depth.
module ufe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ufe_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output ufe_pkg::t_q_head  o_head
);
    import ufe_pkg::*;

    localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

    t_entry                r_mem [QueueDepth];
    logic [PtrWidth-1:0]   r_wr_ptr;
    logic [PtrWidth-1:0]   r_rd_ptr;
    logic [CntWidth-1:0]   r_count;
    logic [PtrWidth-1:0]   n_wr_ptr;
    logic [PtrWidth-1:0]   n_rd_ptr;
    logic [CntWidth-1:0]   n_count;

    assign o_full       = (r_count == CntWidth'(QueueDepth));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ sv/ufe_back.sv @@
// Back end of the UTF-8 filtering encoder: takes one entry from the queue
// and sends its bytes one per transfer. Depends on ufe_pkg.
module ufe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ufe_pkg::t_q_head  i_head,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [ufe_pkg::ByteWidth-1:0] o_tdata,
    output logic              o_tlast
);
    import ufe_pkg::*;

    logic                                r_busy;
    logic [1:0]                          r_idx;
    t_len                                r_len_m1;
    logic [MaxBytes-1:0][ByteWidth-1:0]  r_bytes;
    logic                                n_busy;
    logic [1:0]                          n_idx;
    logic                                w_fire;
    logic                                w_done;
    logic                                w_load;

    assign w_fire = r_busy && i_tready;
    assign w_done = w_fire && (r_idx == r_len_m1);
    // The next entry loads in the same cycle as the last byte of the current one.
    assign w_load = i_head.valid && (!r_busy || w_done);
    assign o_pop  = w_load;

    assign o_tvalid = r_busy;
    assign o_tdata  = r_bytes[r_idx];
    assign o_tlast  = (r_idx == r_len_m1);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_len_m1 <= i_head.entry.len_m1;
            r_bytes  <= i_head.entry.bytes;
        end
    end

endmodule

@@ test/utf8_filtering_encoder_tb.sv @@
// Testbench for utf8_filtering_encoder: sends code points, predicts the UTF-8 byte stream
// in both filter settings and checks every output transfer, with and without random idling.
// Depends on ufe_pkg and the utf8_filtering_encoder RTL.
module utf8_filtering_encoder_tb;
    import ufe_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 8;
    localparam int RandomItems = 50;

    // Code points around which the filter and the sequence length change.
    localparam logic [31:0] RangeBoundaries [12] = '{
        32'h0000_000A, 32'h0000_0020, 32'h0000_007F, 32'h0000_00A0,
        32'h0000_0800, 32'h0000_D800, 32'h0000_E000, 32'h0000_FFFE,
        32'h0001_0000, 32'h000F_0000, 32'h0010_0000, 32'h0011_0000
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_utf8_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_tvalid      = 1'b0;
    logic [31:0] s_tdata       = '0;
    logic        m_tready      = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_utf8_byte  expected_bytes [$];
    logic        encode_all_model = 1'b0;
    int          mismatch_count   = 0;
    int          cycle_count      = 0;
    int          src_idle_pct     = 0;
    int          sink_idle_pct    = 0;

    utf8_filtering_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Number of UTF-8 bytes for a code point, zero when it is dropped.
    function automatic int utf8_length(logic [31:0] cp, logic all);
        if (cp > MaxScalar) return 0;
        if (!all) begin
            if (cp < 32'h20 && cp != 32'h0A) return 0;
            if (cp >= 32'h7F && cp <= 32'h9F) return 0;
            if (cp >= 32'hD800 && cp <= 32'hDFFF) return 0;
            if (cp >= 32'hFFFE && cp <= 32'hFFFF) return 0;
            if (cp >= 32'hF_0000 && cp <= 32'hF_FFFD) return 0;
            if (cp >= 32'h10_0000 && cp <= 32'h10_FFFD) return 0;
        end
        if (cp < 32'h80) return 1;
        if (cp < 32'h800) return 2;
        if (cp < 32'h1_0000) return 3;
        return 4;
    endfunction

    task automatic predict_utf8_bytes(input logic [31:0] cp);
        int          n;
        logic [31:0] seg;
        logic [7:0]  lead;
        t_utf8_byte  b;
        begin
            n = utf8_length(cp, encode_all_model);
            case (n)
                2: lead = Lead2Mark;
                3: lead = Lead3Mark;
                4: lead = Lead4Mark;
                default: lead = 8'h00;
            endcase
            for (int k = 0; k < n; k++) begin
                seg = cp >> (6 * (n - 1 - k));
                if (k == 0) begin
                    b.out_byte = lead | seg[7:0];
                end else begin
                    b.out_byte = ContMark | {2'b00, seg[5:0]};
                end
                b.last_byte = (k == n - 1);
                expected_bytes.push_back(b);
            end
        end
    endtask

    // Output side: random back-pressure and a check of every transfer.
    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected none, got %02h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last_byte) begin
                        $error("last_byte: expected %0b, got %0b", want.last_byte, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Holds tvalid high after the transfer so back-to-back items need no extra drive.
    task automatic send_code_point(input logic [31:0] cp);
        begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= cp;
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            predict_utf8_bytes(cp);
        end
    endtask

    // Drops tvalid, waits until every expected byte has been checked, then adds an idle tail.
    task automatic wait_for_drain();
        begin
            s_tvalid <= 1'b0;
            while (expected_bytes.size() != 0) @(posedge i_clk);
            repeat (DrainCycles) @(posedge i_clk);
        end
    endtask

    task automatic set_encode_all(input logic value);
        begin
            wait_for_drain();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(posedge i_clk);
            cfg_wr_en <= 1'b0;
            encode_all_model = value;
        end
    endtask

    // Filter edges: controls, line feed, the C1 block, surrogates, noncharacters,
    // private use and the value just past the last scalar.
    task automatic test_filtered_boundaries();
        logic [31:0] cps [14];
        begin
            cps = '{32'h0, 32'h0A, 32'h1F, 32'h20, 32'h7F, 32'h9F, 32'hA0, 32'hDFFF,
                    32'hFFFE, 32'hF_0000, 32'hF_FFFE, 32'h10_FFFD, 32'h10_FFFE,
                    32'h11_0000};
            set_encode_all(1'b0);
            foreach (cps[i]) send_code_point(cps[i]);
        end
    endtask

    // Length boundaries, values that are only encoded with filtering off, and out-of-range values.
    task automatic test_encode_all_boundaries();
        logic [31:0] cps [11];
        begin
            cps = '{32'h7F, 32'h7FF, 32'h800, 32'hD800, 32'hFFFF, 32'h1_0000,
                    32'hF_FFFD, 32'h10_0000, 32'h10_FFFF, 32'h11_0000, 32'hFFFF_FFFF};
            set_encode_all(1'b1);
            foreach (cps[i]) send_code_point(cps[i]);
        end
    endtask

    function automatic logic [31:0] random_code_point();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(32'h7F);
            2:       return $urandom_range(32'h7FF, 32'h80);
            3:       return $urandom_range(32'hFFFF, 32'h800);
            4, 5:    return $urandom_range(32'h10_FFFF, 32'h1_0000);
            6, 7:    return RangeBoundaries[$urandom_range(11)] + $urandom_range(4) - 2;
            default: return $urandom() & 32'h001F_FFFF;
        endcase
    endfunction

    task automatic test_random_code_points(input logic all, input int count);
        begin
            set_encode_all(all);
            repeat (count) send_code_point(random_code_point());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 31;
        sink_idle_pct = 84;
        test_filtered_boundaries();
        test_encode_all_boundaries();
        test_random_code_points(1'b0, RandomItems);
        test_random_code_points(1'b1, RandomItems);

        src_idle_pct  = 84;
        sink_idle_pct = 31;
        test_random_code_points(1'b1, RandomItems);
        test_random_code_points(1'b0, RandomItems);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_code_points(1'b0, RandomItems);
        test_random_code_points(1'b1, RandomItems);

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ufe_pkg.sv
sv/ufe_front.sv
sv/ufe_queue.sv
sv/ufe_back.sv
sv/utf8_filtering_encoder.sv
test/utf8_filtering_encoder_tb.sv
